### hdl/amp_pulse_mode_sequencer_top_macros.svh
// Assertion macros used by the checker file of the amplifier pulse-mode sequencer.
`ifndef AMP_PULSE_MODE_SEQUENCER_TOP_MACROS_SVH
`define AMP_PULSE_MODE_SEQUENCER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define APS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sequencer assertion failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define APS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sequencer assertion failed");

`endif

### hdl/aps_pkg.sv
// Package with the types, codes and timing constants of the amplifier pulse-mode sequencer.
package aps_pkg;

    localparam int CHANNELS     = 4;
    localparam int CH_W         = 2;
    localparam int NUM_CH_CODES = 1 << CH_W;
    localparam int MODE_W       = 4;
    localparam int PIN_W        = 4;
    localparam int TIMER_W      = 17;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 4;
    localparam int REQ_W        = 2;

    localparam logic [PIN_W-1:0] CH_MASK = PIN_W'((1 << CHANNELS) - 1);

    localparam logic [MODE_W-1:0] MODE_LIMIT = MODE_W'(10);

    localparam logic [TIMER_W-1:0] T_SHUT        = TIMER_W'(100000);
    localparam logic [TIMER_W-1:0] T_START       = TIMER_W'(300);
    localparam logic [TIMER_W-1:0] T_GAP         = TIMER_W'(20);
    localparam logic [TIMER_W-1:0] T_LONG_PULSE  = TIMER_W'(20);
    localparam logic [TIMER_W-1:0] T_SHORT_PULSE = TIMER_W'(2);
    localparam logic [TIMER_W-1:0] T_WORK        = TIMER_W'(300);
    localparam logic [TIMER_W-1:0] T_SETTLE      = TIMER_W'(22000);

    localparam logic [REQ_W-1:0] REQ_ON  = REQ_W'(1);
    localparam logic [REQ_W-1:0] REQ_OFF = REQ_W'(2);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SELECT_OVERRIDE = 3'd0,
        CFG_CHIP_VARIANT    = 3'd1,
        CFG_MODE_CH0        = 3'd2,
        CFG_MODE_CH1        = 3'd3,
        CFG_MODE_CH2        = 3'd4,
        CFG_MODE_CH3        = 3'd5
    } cfg_index_t;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_SHUT   = 3'd1,
        PH_STA_H  = 3'd2,
        PH_STA_L  = 3'd3,
        PH_PUL_H  = 3'd4,
        PH_PUL_L  = 3'd5,
        PH_WORK   = 3'd6,
        PH_SETTLE = 3'd7
    } phase_t;

    typedef struct packed {
        logic [MODE_W-1:0]                   select_override;
        logic                                chip_variant;
        logic [NUM_CH_CODES-1:0][MODE_W-1:0] mode;
    } cfg_t;

    typedef struct packed {
        logic [PIN_W-1:0]  pin_levels;
        logic              busy_res;
        logic              accepted;
        logic              done_res;
        logic [MODE_W-1:0] channel_mode;
    } result_t;

endpackage

### hdl/aps_cfg_regs.sv
// Configuration register file of the amplifier pulse-mode sequencer.
module aps_cfg_regs
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [aps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [aps_pkg::CFG_DATA_W-1:0] cfg_data,
    output aps_pkg::cfg_t                  cfg
);

    aps_pkg::cfg_t cfg_reg;
    aps_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (aps_pkg::cfg_index_t'(cfg_index))
                aps_pkg::CFG_SELECT_OVERRIDE: cfg_next.select_override = cfg_data;
                aps_pkg::CFG_CHIP_VARIANT:    cfg_next.chip_variant    = cfg_data[0];
                aps_pkg::CFG_MODE_CH0:        cfg_next.mode[0]         = cfg_data;
                aps_pkg::CFG_MODE_CH1:        cfg_next.mode[1]         = cfg_data;
                aps_pkg::CFG_MODE_CH2:        cfg_next.mode[2]         = cfg_data;
                aps_pkg::CFG_MODE_CH3:        cfg_next.mode[3]         = cfg_data;
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### hdl/aps_seq_core.sv
// Sequencer state and the single-pass next-state and result logic for one tick.
module aps_seq_core
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      step,
    input  logic [aps_pkg::REQ_W-1:0] req_type,
    input  logic [aps_pkg::CH_W-1:0]  channel,
    input  aps_pkg::cfg_t             cfg,
    output aps_pkg::result_t          result
);

    aps_pkg::phase_t                    phase_reg;
    aps_pkg::phase_t                    phase_next;
    logic [aps_pkg::TIMER_W-1:0]        timer_reg;
    logic [aps_pkg::TIMER_W-1:0]        timer_next;
    logic [aps_pkg::MODE_W-1:0]         pulses_reg;
    logic [aps_pkg::MODE_W-1:0]         pulses_next;
    logic [aps_pkg::CH_W-1:0]           active_reg;
    logic [aps_pkg::CH_W-1:0]           active_next;
    logic [aps_pkg::PIN_W-1:0]          pin_reg;
    logic [aps_pkg::PIN_W-1:0]          pin_next;
    logic                               short_reg;
    logic                               short_next;
    logic                               on_reg;
    logic                               on_next;
    logic [aps_pkg::NUM_CH_CODES-1:0][aps_pkg::MODE_W-1:0] rec_reg;
    logic [aps_pkg::NUM_CH_CODES-1:0][aps_pkg::MODE_W-1:0] rec_next;

    logic                        ch_ok;
    logic                        acc;
    logic                        done;
    logic                        do_enter;
    aps_pkg::phase_t             enter_ph;
    logic [aps_pkg::MODE_W-1:0]  pulses_base;
    logic [aps_pkg::TIMER_W-1:0] timer_dec;
    logic                        pin_wr;
    logic                        pin_lvl;
    logic [aps_pkg::MODE_W-1:0]  mode_own;
    logic [aps_pkg::MODE_W-1:0]  mode_eff;

    assign ch_ok = ({1'b0, channel} < (aps_pkg::CH_W + 1)'(aps_pkg::CHANNELS));
    assign mode_own = cfg.mode[channel];
    assign mode_eff = (cfg.select_override != '0) ? cfg.select_override :
                      ((mode_own > aps_pkg::MODE_LIMIT) ? '0 : mode_own);
    assign timer_dec = (timer_reg != '0) ? timer_reg - 1'b1 : timer_reg;

    always_comb
    begin
        phase_next  = phase_reg;
        timer_next  = timer_reg;
        pulses_next = pulses_reg;
        active_next = active_reg;
        pin_next    = pin_reg;
        short_next  = short_reg;
        on_next     = on_reg;
        rec_next    = rec_reg;
        acc         = 1'b0;
        done        = 1'b0;
        do_enter    = 1'b0;
        enter_ph    = aps_pkg::PH_IDLE;
        pulses_base = pulses_reg;
        pin_wr      = 1'b0;
        pin_lvl     = 1'b0;

        if (phase_reg != aps_pkg::PH_IDLE)
        begin
            timer_next = timer_dec;
            if (timer_dec == '0)
            begin
                do_enter = 1'b1;
                unique case (phase_reg)
                    aps_pkg::PH_SHUT:
                    begin
                        if (on_reg)
                        begin
                            enter_ph = aps_pkg::PH_STA_H;
                        end
                        else
                        begin
                            enter_ph = aps_pkg::PH_IDLE;
                            done     = 1'b1;
                        end
                    end
                    aps_pkg::PH_STA_H: enter_ph = aps_pkg::PH_STA_L;
                    aps_pkg::PH_STA_L, aps_pkg::PH_PUL_L:
                    begin
                        enter_ph = (pulses_base != '0) ? aps_pkg::PH_PUL_H :
                                   (short_reg ? aps_pkg::PH_SETTLE : aps_pkg::PH_WORK);
                    end
                    aps_pkg::PH_PUL_H: enter_ph = aps_pkg::PH_PUL_L;
                    aps_pkg::PH_WORK:  enter_ph = aps_pkg::PH_SETTLE;
                    default:
                    begin
                        enter_ph = aps_pkg::PH_IDLE;
                        done     = 1'b1;
                    end
                endcase
            end
        end
        else if (((req_type == aps_pkg::REQ_ON) || (req_type == aps_pkg::REQ_OFF)) && ch_ok)
        begin
            acc         = 1'b1;
            active_next = channel;
            short_next  = cfg.chip_variant;
            if (req_type == aps_pkg::REQ_OFF)
            begin
                rec_next[channel] = '0;
                on_next           = 1'b0;
                if (cfg.chip_variant)
                begin
                    pin_wr  = 1'b1;
                    pin_lvl = 1'b0;
                end
                else
                begin
                    do_enter = 1'b1;
                    enter_ph = aps_pkg::PH_SHUT;
                end
            end
            else
            begin
                rec_next[channel] = mode_eff;
                on_next           = 1'b1;
                pulses_base       = (mode_eff > 1) ? mode_eff - 1'b1 : '0;
                pulses_next       = pulses_base;
                do_enter          = 1'b1;
                if (cfg.chip_variant)
                begin
                    enter_ph = (pulses_base != '0) ? aps_pkg::PH_PUL_H : aps_pkg::PH_SETTLE;
                end
                else
                begin
                    enter_ph = aps_pkg::PH_SHUT;
                end
            end
        end

        if (do_enter)
        begin
            phase_next = enter_ph;
            unique case (enter_ph)
                aps_pkg::PH_SHUT:
                begin
                    pin_wr = 1'b1; pin_lvl = 1'b0; timer_next = aps_pkg::T_SHUT;
                end
                aps_pkg::PH_STA_H:
                begin
                    pin_wr = 1'b1; pin_lvl = 1'b1; timer_next = aps_pkg::T_START;
                end
                aps_pkg::PH_STA_L:
                begin
                    pin_wr = 1'b1; pin_lvl = 1'b0; timer_next = aps_pkg::T_GAP;
                end
                aps_pkg::PH_PUL_H:
                begin
                    pin_wr      = 1'b1;
                    pin_lvl     = 1'b1;
                    timer_next  = short_next ? aps_pkg::T_SHORT_PULSE : aps_pkg::T_LONG_PULSE;
                    pulses_next = pulses_base - 1'b1;
                end
                aps_pkg::PH_PUL_L:
                begin
                    pin_wr     = 1'b1;
                    pin_lvl    = 1'b0;
                    timer_next = short_next ? aps_pkg::T_SHORT_PULSE : aps_pkg::T_LONG_PULSE;
                end
                aps_pkg::PH_WORK:
                begin
                    pin_wr = 1'b1; pin_lvl = 1'b1; timer_next = aps_pkg::T_WORK;
                end
                aps_pkg::PH_SETTLE:
                begin
                    pin_wr = 1'b1; pin_lvl = 1'b1; timer_next = aps_pkg::T_SETTLE;
                end
                default:
                begin
                    timer_next = '0;
                end
            endcase
        end

        if (pin_wr)
        begin
            pin_next[active_next] = pin_lvl;
        end
    end

    always_comb
    begin
        result.pin_levels   = pin_next & aps_pkg::CH_MASK;
        result.busy_res     = (phase_next != aps_pkg::PH_IDLE);
        result.accepted     = acc;
        result.done_res     = done;
        result.channel_mode = ch_ok ? rec_next[channel] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= aps_pkg::PH_IDLE;
            timer_reg  <= '0;
            pulses_reg <= '0;
            active_reg <= '0;
            pin_reg    <= '0;
            short_reg  <= 1'b0;
            on_reg     <= 1'b0;
            rec_reg    <= '0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            timer_reg  <= timer_next;
            pulses_reg <= pulses_next;
            active_reg <= active_next;
            pin_reg    <= pin_next;
            short_reg  <= short_next;
            on_reg     <= on_next;
            rec_reg    <= rec_next;
        end
    end

endmodule

### hdl/aps_out_buf.sv
// Result register with a skid stage between the sequencer and the result channel.
module aps_out_buf
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  aps_pkg::result_t push_data,
    output logic             full,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output aps_pkg::result_t rsp_data
);

    logic             out_valid_reg;
    logic             out_valid_next;
    logic             skid_valid_reg;
    logic             skid_valid_next;
    aps_pkg::result_t out_data_reg;
    aps_pkg::result_t out_data_next;
    aps_pkg::result_t skid_data_reg;
    aps_pkg::result_t skid_data_next;

    assign full      = skid_valid_reg;
    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_data_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || !rsp_stall)
        begin
            if (skid_valid_reg)
            begin
                out_data_next   = skid_data_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_data_next  = push_data;
                out_valid_next = push;
            end
        end
        else if (push)
        begin
            skid_data_next  = push_data;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

### hdl/amp_pulse_mode_sequencer_top.sv
// Top level of the amplifier enable-pin pulse-mode sequencer.
// The result of each accepted item is registered in the output buffer before it is offered on the result channel.
// Throughput: one item per cycle while req_stall is low; the whole tick is handled by one pass of the sequencer logic.
// A two-entry output buffer lets items be taken while one result waits to be collected.
// Reset (rst_n low, asynchronous) clears the registers, the sequence state and the mode record.
module amp_pulse_mode_sequencer_top
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_stall,
    input  logic [aps_pkg::REQ_W-1:0]      req_type,
    input  logic [aps_pkg::CH_W-1:0]       channel,
    output logic                           rsp_valid,
    input  logic                           rsp_stall,
    output logic [aps_pkg::PIN_W-1:0]      pin_levels,
    output logic                           busy_res,
    output logic                           accepted,
    output logic                           done_res,
    output logic [aps_pkg::MODE_W-1:0]     channel_mode,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [aps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [aps_pkg::CFG_DATA_W-1:0] cfg_data
);

    aps_pkg::cfg_t    cfg;
    aps_pkg::result_t core_result;
    aps_pkg::result_t rsp_data;
    logic             step;
    logic             buf_full;

    assign req_stall = buf_full;
    assign step      = req_valid && !buf_full;

    aps_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    aps_seq_core u_core
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .req_type (req_type),
        .channel  (channel),
        .cfg      (cfg),
        .result   (core_result)
    );

    aps_out_buf u_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (step),
        .push_data (core_result),
        .full      (buf_full),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    assign pin_levels   = rsp_data.pin_levels;
    assign busy_res     = rsp_data.busy_res;
    assign accepted     = rsp_data.accepted;
    assign done_res     = rsp_data.done_res;
    assign channel_mode = rsp_data.channel_mode;

endmodule

### hdl/aps_checker.sv
// Port-level checker of the amplifier pulse-mode sequencer and its bind to the top level.
`include "amp_pulse_mode_sequencer_top_macros.svh"

module aps_checker
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       req_stall,
    input logic                       rsp_valid,
    input logic                       rsp_stall,
    input logic [aps_pkg::PIN_W-1:0]  pin_levels,
    input logic                       busy_res,
    input logic                       accepted,
    input logic                       done_res,
    input logic [aps_pkg::MODE_W-1:0] channel_mode
);

    // A finishing sequence leaves the block idle, and a finish never coincides with a start.
    `APS_ASSERT_SAME(a_done_leaves_idle, rsp_valid && done_res, !busy_res && !accepted)

    // The input side only stalls after a result was held back on the output side.
    `APS_ASSERT_SAME(a_stall_cause, req_stall, $past(rsp_valid && rsp_stall))

    // Only an off command on the short-pulse chip is taken without starting a sequence, so an
    // accepted item that leaves the block idle has cleared the mode of the addressed channel.
    `APS_ASSERT_SAME(a_off_accept, rsp_valid && accepted && !busy_res, channel_mode == '0)

    // A held result keeps its payload.
    `APS_ASSERT_NEXT(a_hold, rsp_valid && rsp_stall,
                     rsp_valid && $stable(pin_levels) && $stable(channel_mode))

endmodule

bind amp_pulse_mode_sequencer_top aps_checker u_aps_checker (.*);

### tb/sv/amp_pulse_mode_sequencer_top_tb.sv
// Self-checking testbench of the amplifier pulse-mode sequencer, with a tick-accurate scoreboard.
`timescale 1ns / 1ps

module amp_pulse_mode_sequencer_top_tb;
    import aps_pkg::*;

    localparam logic [REQ_W-1:0]     REQ_TICK       = 2'd0;
    localparam logic [REQ_W-1:0]     REQ_SPARE      = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI  = 3'd7;
    localparam int                   LONG_IDLE_MAX  = 40;
    localparam int                   PRESSURE_HOLD  = 300;
    localparam int                   OFF_ITEMS      = 150;
    localparam int                   NOISE_ITEMS    = 830;
    // Well above a run of about a thousand items in which each one meets the longest
    // gap and the longest stall.
    localparam longint               CYCLE_LIMIT    = 64'd1_000_000;

    class pin_sequence_scoreboard;
        logic [MODE_W-1:0]  override_mode;
        logic               short_chip;
        logic [MODE_W-1:0]  own_mode [NUM_CH_CODES];
        phase_t             step_phase;
        logic [TIMER_W-1:0] ticks_left;
        logic [MODE_W-1:0]  pulses_left;
        logic [CH_W-1:0]    live_ch;
        logic [PIN_W-1:0]   pins;
        logic [MODE_W-1:0]  on_mode [NUM_CH_CODES];
        bit                 run_short;
        bit                 run_on;
        result_t            expected_ticks [$];
        int                 mismatches;
        int                 checked;
        int                 taken;
        int                 turned_away;
        int                 finished;

        function new();
            override_mode = '0;
            short_chip    = 1'b0;
            step_phase    = PH_IDLE;
            ticks_left    = '0;
            pulses_left   = '0;
            live_ch       = '0;
            pins          = '0;
            run_short     = 1'b0;
            run_on        = 1'b0;
            for (int i = 0; i < NUM_CH_CODES; i++)
            begin
                own_mode[i] = '0;
                on_mode[i]  = '0;
            end
            mismatches  = 0;
            checked     = 0;
            taken       = 0;
            turned_away = 0;
            finished    = 0;
        endfunction

        function bit idle();
            return step_phase == PH_IDLE;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
            case (idx)
                CFG_SELECT_OVERRIDE: override_mode = d;
                CFG_CHIP_VARIANT:    short_chip = d[0];
                CFG_MODE_CH0:        own_mode[0] = d;
                CFG_MODE_CH1:        own_mode[1] = d;
                CFG_MODE_CH2:        own_mode[2] = d;
                CFG_MODE_CH3:        own_mode[3] = d;
                default:             ;
            endcase
        endfunction

        function void hold_pin(logic level, logic [TIMER_W-1:0] len);
            pins[live_ch] = level;
            ticks_left = len;
        endfunction

        function void enter_phase(phase_t p);
            logic [TIMER_W-1:0] pulse_len;
            pulse_len = run_short ? T_SHORT_PULSE : T_LONG_PULSE;
            step_phase = p;
            if (p == PH_PUL_H)
                pulses_left = pulses_left - 1'b1;
            case (p)
                PH_SHUT:   hold_pin(1'b0, T_SHUT);
                PH_STA_H:  hold_pin(1'b1, T_START);
                PH_STA_L:  hold_pin(1'b0, T_GAP);
                PH_PUL_H:  hold_pin(1'b1, pulse_len);
                PH_PUL_L:  hold_pin(1'b0, pulse_len);
                PH_WORK:   hold_pin(1'b1, T_WORK);
                PH_SETTLE: hold_pin(1'b1, T_SETTLE);
                default:   ticks_left = '0;
            endcase
        endfunction

        function void after_gap();
            if (pulses_left != 0)
                enter_phase(PH_PUL_H);
            else if (run_short)
                enter_phase(PH_SETTLE);
            else
                enter_phase(PH_WORK);
        endfunction

        function bit advance();
            if (step_phase == PH_IDLE)
                return 1'b0;
            if (ticks_left > 0)
                ticks_left = ticks_left - 1'b1;
            if (ticks_left != 0)
                return 1'b0;
            case (step_phase)
                PH_SHUT:
                begin
                    if (run_on)
                        enter_phase(PH_STA_H);
                    else
                        enter_phase(PH_IDLE);
                end
                PH_STA_H:  enter_phase(PH_STA_L);
                PH_STA_L:  after_gap();
                PH_PUL_H:  enter_phase(PH_PUL_L);
                PH_PUL_L:  after_gap();
                PH_WORK:   enter_phase(PH_SETTLE);
                default:   enter_phase(PH_IDLE);
            endcase
            return step_phase == PH_IDLE;
        endfunction

        function void note_tick(logic [REQ_W-1:0] rt, logic [CH_W-1:0] ch);
            result_t           r;
            bit                was_busy;
            bit                took;
            bit                ended;
            logic [MODE_W-1:0] m;
            was_busy = step_phase != PH_IDLE;
            took     = 1'b0;
            ended    = 1'b0;
            if (was_busy)
            begin
                ended = advance();
                if (rt == REQ_ON || rt == REQ_OFF)
                    turned_away++;
            end
            else if ((rt == REQ_ON || rt == REQ_OFF) && ch < CHANNELS)
            begin
                took      = 1'b1;
                live_ch   = ch;
                run_short = short_chip;
                if (rt == REQ_OFF)
                begin
                    on_mode[ch] = '0;
                    run_on      = 1'b0;
                    if (run_short)
                        pins[live_ch] = 1'b0;
                    else
                        enter_phase(PH_SHUT);
                end
                else
                begin
                    m = own_mode[ch];
                    if (m > MODE_LIMIT)
                        m = '0;
                    if (override_mode != 0)
                        m = override_mode;
                    on_mode[ch] = m;
                    run_on      = 1'b1;
                    pulses_left = (m > 1) ? m - 1'b1 : '0;
                    if (run_short)
                        after_gap();
                    else
                        enter_phase(PH_SHUT);
                end
            end
            if (took)
                taken++;
            if (ended)
                finished++;
            r.pin_levels   = pins & CH_MASK;
            r.busy_res     = step_phase != PH_IDLE;
            r.accepted     = took;
            r.done_res     = ended;
            r.channel_mode = (ch < CHANNELS) ? on_mode[ch] : '0;
            expected_ticks.push_back(r);
        endfunction

        function void note_mismatch(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("MISMATCH: %s", msg);
        endfunction

        function void check_field(string field, logic [3:0] want, logic [3:0] seen);
            if (seen !== want)
                note_mismatch($sformatf("item %0d %s: expected %0d, got %0d",
                                        checked, field, want, seen));
        endfunction

        function void check_tick(result_t got);
            result_t want;
            if (expected_ticks.size() == 0)
            begin
                note_mismatch($sformatf("result with no item waiting: %h", got));
                return;
            end
            want = expected_ticks.pop_front();
            check_field("pin_levels", want.pin_levels, got.pin_levels);
            check_field("busy_res", 4'(want.busy_res), 4'(got.busy_res));
            check_field("accepted", 4'(want.accepted), 4'(got.accepted));
            check_field("done_res", 4'(want.done_res), 4'(got.done_res));
            check_field("channel_mode", want.channel_mode, got.channel_mode);
            checked++;
        endfunction
    endclass

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  req_valid    = 1'b0;
    logic                  req_stall;
    logic [REQ_W-1:0]      req_type     = '0;
    logic [CH_W-1:0]       channel      = '0;
    logic                  rsp_valid;
    logic                  rsp_stall    = 1'b0;
    logic [PIN_W-1:0]      pin_levels;
    logic                  busy_res;
    logic                  accepted;
    logic                  done_res;
    logic [MODE_W-1:0]     channel_mode;
    logic                  cfg_valid    = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;

    logic                  calm         = 1'b0;
    logic                  hold_request = 1'b0;
    longint                cycle_count  = 0;
    int                    held_cycles  = 0;
    pin_sequence_scoreboard book;

    amp_pulse_mode_sequencer_top dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .req_type     (req_type),
        .channel      (channel),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .pin_levels   (pin_levels),
        .busy_res     (busy_res),
        .accepted     (accepted),
        .done_res     (done_res),
        .channel_mode (channel_mode),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 999);
        if (calm || r < 850)
            return 0;
        if (r < 995)
            return $urandom_range(1, 3);
        return $urandom_range(10, LONG_IDLE_MAX);
    endfunction

    initial
    begin
        int      run;
        bit      hold_done;
        result_t got;
        run       = 0;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_valid && !rsp_stall)
            begin
                got.pin_levels   = pin_levels;
                got.busy_res     = busy_res;
                got.accepted     = accepted;
                got.done_res     = done_res;
                got.channel_mode = channel_mode;
                book.check_tick(got);
            end
            if (hold_request && !hold_done)
            begin
                hold_done = 1'b1;
                run       = PRESSURE_HOLD;
            end
            else if (run == 0)
                run = pick_idle();
            if (run > 0)
            begin
                rsp_stall <= 1'b1;
                run--;
            end
            else
                rsp_stall <= 1'b0;
        end
    end

    task automatic send_item(input logic [REQ_W-1:0] rt, input logic [CH_W-1:0] ch);
        int gap;
        gap = pick_idle();
        if ($urandom_range(0, 2999) == 0)
            calm <= !calm;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_type  <= rt;
        channel   <= ch;
        @(posedge clk);
        while (req_stall)
        begin
            held_cycles++;
            @(posedge clk);
        end
        book.note_tick(rt, ch);
    endtask

    // Mostly plain ticks; now and then a command that lands while a sequence runs.
    task automatic send_noise();
        logic [REQ_W-1:0] rt;
        rt = $urandom_range(0, 1) ? REQ_SPARE : REQ_TICK;
        if ($urandom_range(0, 19) == 0)
            rt = $urandom_range(0, 1) ? REQ_ON : REQ_OFF;
        send_item(rt, CH_W'($urandom_range(0, CHANNELS - 1)));
    endtask

    task automatic quiesce();
        req_valid <= 1'b0;
        while (book.expected_ticks.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        book.write_reg(idx, d);
    endtask

    task automatic write_settings(input logic [MODE_W-1:0] ovr, input logic chip,
                                  input logic [MODE_W-1:0] m0, input logic [MODE_W-1:0] m1,
                                  input logic [MODE_W-1:0] m2, input logic [MODE_W-1:0] m3);
        write_reg($urandom_range(0, 1) ? CFG_UNUSED_HI : CFG_UNUSED_LO,
                  CFG_DATA_W'($urandom_range(0, 15)));
        write_reg(CFG_SELECT_OVERRIDE, ovr);
        write_reg(CFG_CHIP_VARIANT, CFG_DATA_W'(chip));
        write_reg(CFG_MODE_CH0, m0);
        write_reg(CFG_MODE_CH1, m1);
        write_reg(CFG_MODE_CH2, m2);
        write_reg(CFG_MODE_CH3, m3);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [MODE_W-1:0] modes [CHANNELS];
        logic [MODE_W-1:0] ovr;
        logic [REQ_W-1:0]  rt;
        logic [CH_W-1:0]   ch;
        int                r;
        book = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(REQ_TICK, 2'd0);
        send_item(REQ_SPARE, 2'd3);
        send_item(REQ_TICK, 2'd2);
        quiesce();

        // On the short-pulse chip an off command takes effect at once and leaves the block idle.
        ovr = MODE_W'($urandom_range(0, 15));
        for (int i = 0; i < CHANNELS; i++)
            modes[i] = MODE_W'($urandom_range(0, 15));
        write_settings(ovr, 1'b1, modes[0], modes[1], modes[2], modes[3]);
        for (int n = 0; n < OFF_ITEMS; n++)
        begin
            ch = CH_W'($urandom_range(0, CHANNELS - 1));
            r  = $urandom_range(0, 99);
            if (r < 40)
                rt = REQ_OFF;
            else if (r < 70)
                rt = REQ_TICK;
            else
                rt = REQ_SPARE;
            send_item(rt, ch);
        end
        quiesce();

        write_settings(4'd0, 1'b1, 4'd10, 4'd11, 4'd0, 4'd15);
        for (int i = 0; i < CHANNELS; i++)
            send_item(REQ_OFF, CH_W'(i));
        send_item(REQ_SPARE, 2'd1);
        // Own mode at the limit: nine short pulses, then the settle time.
        send_item(REQ_ON, 2'd0);
        // The sequence is running, so these commands are refused.
        send_item(REQ_ON, 2'd1);
        send_item(REQ_OFF, 2'd3);
        send_item(REQ_TICK, 2'd0);
        send_item(REQ_SPARE, 2'd2);
        hold_request <= 1'b1;
        for (int n = 0; n < NOISE_ITEMS; n++)
            send_noise();
        quiesce();

        $display("covered %0d items: %0d commands taken, %0d refused during a pulse sequence",
                 book.checked, book.taken, book.turned_away);
        $display("%0d sequences ran to the end; the input was held back on %0d cycles",
                 book.finished, held_cycles);
        if (book.mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

### files.f
+incdir+hdl
hdl/aps_pkg.sv
hdl/aps_cfg_regs.sv
hdl/aps_seq_core.sv
hdl/aps_out_buf.sv
hdl/amp_pulse_mode_sequencer_top.sv
hdl/aps_checker.sv
tb/sv/amp_pulse_mode_sequencer_top_tb.sv
